// ===== hw/rtl/mstmf_pkg.sv =====
// ----------------------------------------------------------------------------
// mstmf_pkg: shared types and constants for the multiplexed scan filter
// Word layouts, register indexes, window geometry and the divide-by-three
// reciprocal used by the trimmed mean.
// ----------------------------------------------------------------------------
package mstmf_pkg;

   localparam int SAMPLE_W  = 12;
   localparam int CHAN_W    = 4;
   localparam int CSR_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int PHASE_W   = 4;

   localparam int WINDOW    = 7;
   localparam int FILL_W    = 3;
   localparam int MID_LOW   = 2;
   localparam int SUM_W     = SAMPLE_W + 2;

   // floor(x / 3) == (x * 21846) >> 16 for every x below 2**14
   localparam int                  RECIP_W    = 15;
   localparam logic [RECIP_W-1:0]  DIV3_RECIP = 15'd21846;
   localparam int                  DIV3_SHIFT = 16;
   localparam int                  PROD_W     = SUM_W + RECIP_W;

   localparam logic [FILL_W-1:0]   LAST_FILL  = 3'(WINDOW - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_FILTERED  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_DISCARDS = 2'd2;

   localparam logic [CSR_W-1:0] RST_CHANNELS_IN_USE = 5'd12;
   localparam logic [CSR_W-1:0] RST_FIRST_FILTERED  = 5'd5;
   localparam logic [1:0]       RST_SETTLE_DISCARDS = 2'd1;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                restart;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   channel;
      logic [SAMPLE_W-1:0] filtered_value;
      logic                scan_done;
   } rsp_type;

   typedef struct packed {
      logic              insert;
      logic [FILL_W-1:0] fill;
      logic              load_meta;
      logic              load_pass;
      logic              load_sum;
      logic              load_mean;
      logic [CHAN_W-1:0] channel;
      logic              last;
   } dp_cmd_type;

endpackage

// ===== hw/rtl/mstmf_dpath.sv =====
// ----------------------------------------------------------------------------
// mstmf_dpath: sorted sample store, middle sum, scaling and output register
// A row of seven cells inserts one sample per cycle on insert, ascending;
// the three middle entries are summed, then scaled by a reciprocal of three.
// ----------------------------------------------------------------------------
module mstmf_dpath
   import mstmf_pkg::*;
(
   input  logic       clock,
   input  dp_cmd_type cmd,
   input  req_type    req_data,
   output rsp_type    rsp_data
);

   logic [SAMPLE_W-1:0] store_ff [WINDOW];
   logic [SAMPLE_W-1:0] store_in [WINDOW];
   logic [WINDOW:0]     gt_suffix;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;
   logic [PROD_W-1:0]   prod;
   rsp_type             out_ff;

   // gt_suffix[i]: every filled entry at or above i is greater than the sample
   always_comb begin
      gt_suffix[WINDOW] = 1'b1;
      for (int i = WINDOW - 1; i >= 0; i--) begin
         if (3'(i) >= cmd.fill) begin
            gt_suffix[i] = 1'b1;
         end else begin
            gt_suffix[i] = gt_suffix[i+1] && (store_ff[i] > req_data.sample);
         end
      end
   end

   always_comb begin
      if (!gt_suffix[0]) begin
         store_in[0] = store_ff[0];
      end else begin
         store_in[0] = req_data.sample;
      end
      for (int i = 1; i < WINDOW; i++) begin
         if (3'(i) > cmd.fill || !gt_suffix[i]) begin
            store_in[i] = store_ff[i];
         end else if (gt_suffix[i-1]) begin
            store_in[i] = store_ff[i-1];
         end else begin
            store_in[i] = req_data.sample;
         end
      end
   end

   assign sum_in = SUM_W'(store_ff[MID_LOW]) + SUM_W'(store_ff[MID_LOW+1])
                 + SUM_W'(store_ff[MID_LOW+2]);
   assign prod   = PROD_W'(sum_ff) * PROD_W'(DIV3_RECIP);

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         store_ff <= store_in;
      end
      if (cmd.load_sum) begin
         sum_ff <= sum_in;
      end
      if (cmd.load_meta) begin
         out_ff.channel   <= cmd.channel;
         out_ff.scan_done <= cmd.last;
      end
      if (cmd.load_pass) begin
         out_ff.filtered_value <= req_data.sample;
      end else if (cmd.load_mean) begin
         out_ff.filtered_value <= prod[DIV3_SHIFT +: SAMPLE_W];
      end
   end

   assign rsp_data = out_ff;

endmodule

// ===== hw/rtl/mstmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// mstmf_ctrl: scan sequencer and configuration registers
// Tracks channel and settle phase, decides per word whether it is dropped,
// passed through or inserted, and steps the mean through sum and scale.
// ----------------------------------------------------------------------------
module mstmf_ctrl
   import mstmf_pkg::*;
#(
   parameter int MAX_CHANNELS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_restart,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dp_cmd_type           cmd
);

   typedef enum logic [1:0] {ST_ACCEPT, ST_SUM, ST_SCALE} state_type;

   localparam logic [CSR_W-1:0] MAX_CNT = CSR_W'(MAX_CHANNELS);

   state_type          state_ff, state_in;
   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [CSR_W-1:0]   chans_ff, first_filt_ff;
   logic [1:0]         settle_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [CSR_W-1:0]   count;
   logic               resync;
   logic [CHAN_W-1:0]  chan0, chan_next;
   logic [PHASE_W-1:0] phase0, kraw;
   logic [FILL_W-1:0]  fill;
   logic               settling, pass_thru, last;

   always_comb begin
      if (chans_ff == '0) begin
         count = CSR_W'(1);
      end else if (chans_ff > MAX_CNT) begin
         count = MAX_CNT;
      end else begin
         count = chans_ff;
      end
   end

   assign resync    = req_restart || ({1'b0, chan_ff} >= count);
   assign chan0     = resync ? '0 : chan_ff;
   assign phase0    = resync ? '0 : phase_ff;
   assign settling  = phase0 < PHASE_W'(settle_ff);
   assign kraw      = phase0 - PHASE_W'(settle_ff);
   assign fill      = (kraw > PHASE_W'(LAST_FILL)) ? LAST_FILL : kraw[FILL_W-1:0];
   assign pass_thru = {1'b0, chan0} < first_filt_ff;
   assign last      = {1'b0, chan0} == (count - CSR_W'(1));
   assign chan_next = last ? '0 : chan0 + CHAN_W'(1);

   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.fill     = fill;
      cmd.channel  = chan0;
      cmd.last     = last;
      case (state_ff)
         ST_ACCEPT: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               // a restart or a shrunken count takes effect with this word
               chan_in = chan0;
               if (settling) begin
                  phase_in = phase0 + PHASE_W'(1);
               end else if (pass_thru) begin
                  cmd.load_pass = 1'b1;
                  cmd.load_meta = 1'b1;
                  rsp_valid_in  = 1'b1;
                  chan_in       = chan_next;
                  phase_in      = '0;
               end else begin
                  cmd.insert = 1'b1;
                  if (fill != LAST_FILL) begin
                     phase_in = PHASE_W'(settle_ff) + PHASE_W'(fill) + PHASE_W'(1);
                  end else begin
                     // window full: finish the mean in the sum and scale states
                     cmd.load_meta = 1'b1;
                     chan_in       = chan_next;
                     phase_in      = '0;
                     state_in      = ST_SUM;
                  end
               end
            end
         end
         ST_SUM: begin
            cmd.load_sum = 1'b1;
            state_in     = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.load_mean = 1'b1;
            rsp_valid_in  = 1'b1;
            state_in      = ST_ACCEPT;
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_ACCEPT;
         chan_ff       <= '0;
         phase_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         chans_ff      <= RST_CHANNELS_IN_USE;
         first_filt_ff <= RST_FIRST_FILTERED;
         settle_ff     <= RST_SETTLE_DISCARDS;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_CHANNELS_IN_USE: chans_ff      <= csr_data;
               CSR_FIRST_FILTERED:  first_filt_ff <= csr_data;
               CSR_SETTLE_DISCARDS: settle_ff     <= csr_data[1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/mux_scan_trimmed_mean_filter.sv =====
// ----------------------------------------------------------------------------
// mux_scan_trimmed_mean_filter: multiplexed scan filter, seven-sample trimmed mean
// A pass-through word shows on rsp in the cycle after accept; a filtered
// channel's mean shows after its seventh word, once the sum and scale states pass.
// Throughput: one word per cycle while no result waits and no mean is in progress;
// a waiting result holds req_ready low until rsp_ready, as do the sum and scale states.
// Synchronous reset restores register defaults and channel 0; the sample store
// is not cleared and holds unknown data until filled.
// ----------------------------------------------------------------------------
module mux_scan_trimmed_mean_filter
   import mstmf_pkg::*;
#(
   parameter int MAX_CHANNELS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data
);

   dp_cmd_type cmd;

   mstmf_ctrl #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_data.restart),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd)
   );

   mstmf_dpath u_dpath (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ===== hw/rtl/mstmf_checker.sv =====
// ----------------------------------------------------------------------------
// mstmf_checker: port-level checks for the scan filter
// Watches the req and rsp channels of the top level over time.
// ----------------------------------------------------------------------------
module mstmf_checker
   import mstmf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a result comes from a word accepted in the cycle before (pass) or ahead of the sum and scale states (mean)
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(req_valid && req_ready)
                            || $past(req_valid && req_ready, 3)))
      else $error("rsp word without a matching req word");

   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req accepted while rsp stalled");

endmodule

bind mux_scan_trimmed_mean_filter mstmf_checker u_mstmf_checker (.*);
